// ===== rtl/bfc_pkg.sv =====
package bfc_pkg;

  localparam int CoordFracBits  = 16;
  localparam int MatrixFracBits = 24;

  localparam int CoordW = 32;
  localparam int EntW   = 32;
  localparam int RegW   = 64;
  localparam int ProdW  = 64;
  localparam int SumW   = ProdW + 2;
  localparam int CmpW   = SumW + 1;
  localparam int NumRegs = 8;
  localparam int RegIdxW = $clog2(NumRegs);
  localparam int NumCorners = 8;
  localparam int CodeW = 6;

  typedef enum logic [RegIdxW-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5,
    REG_ROW3_COLS01 = 3'd6,
    REG_ROW3_COLS23 = 3'd7
  } reg_idx_e;

  typedef logic [3:0][3:0][EntW-1:0] mat_t;
  typedef logic [2:0][CoordW-1:0] vec3_t;

  typedef struct packed {
    vec3_t lo;
    vec3_t hi;
  } box_t;

  typedef logic [NumCorners-1:0][3:0][SumW-1:0] clip_t;

endpackage

// ===== rtl/bfc_mat_regs.sv =====
module bfc_mat_regs
  import bfc_pkg::*;
#(
  parameter int MATRIX_FRAC_BITS = MatrixFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_wdata_i,
  output mat_t               mat_o
);

  localparam logic [RegW-1:0] OneLo = RegW'(1) << MATRIX_FRAC_BITS;
  localparam logic [RegW-1:0] OneHi = OneLo << EntW;

  logic [RegW-1:0] regs_q [NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[REG_ROW0_COLS01] <= OneLo;
      regs_q[REG_ROW0_COLS23] <= '0;
      regs_q[REG_ROW1_COLS01] <= OneHi;
      regs_q[REG_ROW1_COLS23] <= '0;
      regs_q[REG_ROW2_COLS01] <= '0;
      regs_q[REG_ROW2_COLS23] <= OneLo;
      regs_q[REG_ROW3_COLS01] <= '0;
      regs_q[REG_ROW3_COLS23] <= OneHi;
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat_o[r][0] = regs_q[2*r][EntW-1:0];
      mat_o[r][1] = regs_q[2*r][RegW-1:EntW];
      mat_o[r][2] = regs_q[2*r+1][EntW-1:0];
      mat_o[r][3] = regs_q[2*r+1][RegW-1:EntW];
    end
  end

endmodule

// ===== rtl/bfc_xform.sv =====
module bfc_xform
  import bfc_pkg::*;
#(
  parameter int COORD_FRAC_BITS = CoordFracBits
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  box_t  box_i,
  input  mat_t  mat_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output clip_t clip_o
);

  // Products of each matrix entry in columns 0-2 with both bounds of its axis; index 1 is the lower bound.
  logic signed [ProdW-1:0] prod_d [4][3][2];
  logic signed [ProdW-1:0] prod_q [4][3][2];
  logic [ProdW-1:0] wterm_d [4];
  logic [ProdW-1:0] wterm_q [4];
  logic [SumW-1:0]  xs_d [4][2];
  logic [SumW-1:0]  xs_q [4][2];
  logic [SumW-1:0]  yz_d [4][2][2];
  logic [SumW-1:0]  yz_q [4][2][2];
  clip_t            sum_d;
  clip_t            sum_q;
  logic             v2_q, v3_q, v4_q;
  logic             rdy2, rdy3, rdy4;
  logic [2:0]       kb;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign in_ready_o  = rdy2;
  assign out_valid_o = v4_q;
  assign clip_o      = sum_q;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c][0] = $signed(mat_i[r][c]) * $signed(box_i.hi[c]);
        prod_d[r][c][1] = $signed(mat_i[r][c]) * $signed(box_i.lo[c]);
      end
      wterm_d[r] = {{(ProdW-EntW){mat_i[r][3][EntW-1]}}, mat_i[r][3]} << COORD_FRAC_BITS;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int b = 0; b < 2; b++) begin
        xs_d[r][b] = {{2{prod_q[r][0][b][ProdW-1]}}, prod_q[r][0][b]}
                   + {{2{wterm_q[r][ProdW-1]}}, wterm_q[r]};
        for (int bz = 0; bz < 2; bz++) begin
          yz_d[r][b][bz] = {{2{prod_q[r][1][b][ProdW-1]}}, prod_q[r][1][b]}
                         + {{2{prod_q[r][2][bz][ProdW-1]}}, prod_q[r][2][bz]};
        end
      end
    end
  end

  always_comb begin
    kb = '0;
    for (int k = 0; k < NumCorners; k++) begin
      kb = 3'(k);
      for (int r = 0; r < 4; r++) begin
        sum_d[k][r] = xs_q[r][kb[0]] + yz_q[r][kb[1]][kb[2]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      prod_q  <= prod_d;
      wterm_q <= wterm_d;
    end
    if (rdy3 && v2_q) begin
      xs_q <= xs_d;
      yz_q <= yz_d;
    end
    if (rdy4 && v3_q) begin
      sum_q <= sum_d;
    end
  end

endmodule

// ===== rtl/bfc_outcode.sv =====
module bfc_outcode
  import bfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  clip_t            clip_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             cullable_o,
  output logic [CodeW-1:0] common_outcode_o
);

  logic             valid_q;
  logic [CodeW-1:0] code_q;
  logic [CodeW-1:0] code_d;
  logic [CodeW-1:0] corner_code;
  logic [CmpW-1:0]  cv;
  logic [CmpW-1:0]  wv;
  logic [CmpW-1:0]  below;
  logic [CmpW-1:0]  above;

  assign in_ready_o       = !valid_q || out_ready_i;
  assign out_valid_o      = valid_q;
  assign common_outcode_o = code_q;
  assign cullable_o       = |code_q;

  // A corner is outside a plane when c + w or w - c is negative.
  always_comb begin
    code_d      = '1;
    corner_code = '0;
    cv          = '0;
    wv          = '0;
    below       = '0;
    above       = '0;
    for (int k = 0; k < NumCorners; k++) begin
      wv = {clip_i[k][3][SumW-1], clip_i[k][3]};
      for (int a = 0; a < 3; a++) begin
        cv    = {clip_i[k][a][SumW-1], clip_i[k][a]};
        below = cv + wv;
        above = wv - cv;
        corner_code[2*a]   = below[CmpW-1];
        corner_code[2*a+1] = above[CmpW-1];
      end
      code_d = code_d & corner_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      code_q <= code_d;
    end
  end

endmodule

// ===== rtl/box_frustum_cull_test.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   x_min_i .. z_max_i, six signed Q16.16
// result    out        out_valid_o / out_ready_i cullable_o, common_outcode_o
// config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One box is accepted per cycle while no stalled result backs up to the input; its result passes through each stage.
// The stages are: input register, 24 parallel 32x32 products, partial sums, corner
// sums, then the plane compares and outcode AND in the result register.
// Reset clears all stage valid bits and loads the identity matrix.
// Ready is chained back through the stages, so a stalled result holds the input in the
// same cycle only when every stage is full; empty stages still take transactions.
module box_frustum_cull_test
  import bfc_pkg::*;
#(
  parameter int COORD_FRAC_BITS  = CoordFracBits,
  parameter int MATRIX_FRAC_BITS = MatrixFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CoordW-1:0]  x_min_i,
  input  logic [CoordW-1:0]  y_min_i,
  input  logic [CoordW-1:0]  z_min_i,
  input  logic [CoordW-1:0]  x_max_i,
  input  logic [CoordW-1:0]  y_max_i,
  input  logic [CoordW-1:0]  z_max_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               cullable_o,
  output logic [CodeW-1:0]   common_outcode_o,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_wdata_i
);

  mat_t  mat;
  box_t  box_q;
  logic  v1_q;
  logic  xf_ready;
  logic  xf_valid;
  clip_t clip;
  logic  oc_ready;

  assign in_ready_o = !v1_q || xf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      box_q.lo <= {z_min_i, y_min_i, x_min_i};
      box_q.hi <= {z_max_i, y_max_i, x_max_i};
    end
  end

  bfc_mat_regs #(
    .MATRIX_FRAC_BITS(MATRIX_FRAC_BITS)
  ) u_mat_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .mat_o      (mat)
  );

  bfc_xform #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_xform (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v1_q),
    .in_ready_o (xf_ready),
    .box_i      (box_q),
    .mat_i      (mat),
    .out_valid_o(xf_valid),
    .out_ready_i(oc_ready),
    .clip_o     (clip)
  );

  bfc_outcode u_outcode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (xf_valid),
    .in_ready_o      (oc_ready),
    .clip_i          (clip),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cullable_o      (cullable_o),
    .common_outcode_o(common_outcode_o)
  );

endmodule

// ===== rtl/bfc_checker.sv =====
module bfc_checker
  import bfc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [CoordW-1:0]  x_min_i,
  input logic [CoordW-1:0]  y_min_i,
  input logic [CoordW-1:0]  z_min_i,
  input logic [CoordW-1:0]  x_max_i,
  input logic [CoordW-1:0]  y_max_i,
  input logic [CoordW-1:0]  z_max_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               cullable_o,
  input logic [CodeW-1:0]   common_outcode_o,
  input logic               cfg_we_i,
  input logic [RegIdxW-1:0] cfg_idx_i,
  input logic [RegW-1:0]    cfg_wdata_i
);

  // A stalled result keeps its valid and its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(common_outcode_o)
      && $stable(cullable_o))
    else $error("result changed while stalled");

  // The cull flag reports exactly whether any plane is common to all corners.
  a_cull_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cullable_o == (common_outcode_o != '0))
    else $error("cull flag disagrees with outcode");

  // Backpressure on the input can only come from a stalled result.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  // No result is offered right after reset is released.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind box_frustum_cull_test bfc_checker u_bfc_checker (.*);

// ===== verif/tb_box_frustum_cull_test.sv =====
`timescale 1ns / 1ps

module tb_box_frustum_cull_test;
  import bfc_pkg::*;

  localparam int Q1 = 1 << CoordFracBits;
  localparam int OneM = 1 << MatrixFracBits;
  localparam int NumPhases = 10;
  localparam int ItemsPerPhase = 188;
  localparam int LongHold = 80;
  localparam int CycleLimit = 400000;
  localparam logic [31:0] EdgeVals [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                          32'h0001_0000, 32'hffff_0000};

  typedef enum {
    MX_IDENTITY, MX_PERSPECTIVE, MX_SMALL_RANDOM, MX_FULL_RANDOM,
    MX_MOST_NEG, MX_MOST_POS, MX_ZERO, MX_ALTERNATING
  } mat_kind_e;

  typedef struct packed {
    logic             cull;
    logic [CodeW-1:0] code;
  } cull_result_t;

  class cull_scoreboard;
    logic [RegW-1:0] matrix_regs [NumRegs];
    cull_result_t    pending_outcodes [$];
    int              n_noted;
    int              n_checked;
    int              n_culled;
    int              n_errors;
    logic [CodeW-1:0] bits_seen;

    function new();
      foreach (matrix_regs[i]) matrix_regs[i] = '0;
      matrix_regs[REG_ROW0_COLS01] = RegW'(OneM);
      matrix_regs[REG_ROW1_COLS01] = RegW'(OneM) << 32;
      matrix_regs[REG_ROW2_COLS23] = RegW'(OneM);
      matrix_regs[REG_ROW3_COLS23] = RegW'(OneM) << 32;
      n_noted = 0;
      n_checked = 0;
      n_culled = 0;
      n_errors = 0;
      bits_seen = '0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [RegW-1:0] value);
      matrix_regs[idx] = value;
    endfunction

    function cull_result_t predict_outcode(box_t b);
      logic signed [127:0] crd [4];
      logic signed [127:0] clip [4];
      logic signed [127:0] ent;
      logic signed [EntW-1:0] half;
      logic [RegW-1:0] word;
      logic [CodeW-1:0] acc;
      logic [CodeW-1:0] code;
      cull_result_t r;
      acc = '1;
      crd[3] = 128'sd1 <<< CoordFracBits;
      for (int k = 0; k < NumCorners; k++) begin
        for (int a = 0; a < 3; a++) begin
          crd[a] = $signed(((k >> a) & 1) != 0 ? b.lo[a] : b.hi[a]);
        end
        for (int r = 0; r < 4; r++) begin
          clip[r] = '0;
          for (int c = 0; c < 4; c++) begin
            word = matrix_regs[r * 2 + c / 2];
            half = (c % 2 != 0) ? word[63:32] : word[31:0];
            ent = half;
            clip[r] = clip[r] + ent * crd[c];
          end
        end
        code = '0;
        for (int r = 0; r < 3; r++) begin
          if (clip[r] + clip[3] < 128'sd0) code[2 * r] = 1'b1;
          if (clip[3] - clip[r] < 128'sd0) code[2 * r + 1] = 1'b1;
        end
        acc &= code;
      end
      r.code = acc;
      r.cull = |acc;
      return r;
    endfunction

    function void note_box(box_t b);
      pending_outcodes.push_back(predict_outcode(b));
      n_noted++;
    endfunction

    function void flag(string msg);
      n_errors++;
      $error("%s", msg);
    endfunction

    function void check_result(logic cull, logic [CodeW-1:0] code);
      cull_result_t want;
      if (pending_outcodes.size() == 0) begin
        flag($sformatf("result (cullable %0b, common_outcode %02h) with no box outstanding",
                       cull, code));
        return;
      end
      want = pending_outcodes.pop_front();
      n_checked++;
      if (want.cull) n_culled++;
      bits_seen |= want.code;
      if (cull !== want.cull)
        flag($sformatf("cullable: expected %0b, got %0b", want.cull, cull));
      if (code !== want.code)
        flag($sformatf("common_outcode: expected %02h, got %02h", want.code, code));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CoordW-1:0]  x_min_i;
  logic [CoordW-1:0]  y_min_i;
  logic [CoordW-1:0]  z_min_i;
  logic [CoordW-1:0]  x_max_i;
  logic [CoordW-1:0]  y_max_i;
  logic [CoordW-1:0]  z_max_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               cullable_o;
  logic [CodeW-1:0]   common_outcode_o;
  logic               cfg_we_i;
  logic [RegIdxW-1:0] cfg_idx_i;
  logic [RegW-1:0]    cfg_wdata_i;

  cull_scoreboard sb;
  bit  no_idle;
  bit  long_hold_req;
  int  n_long_holds;
  int  cycle_count;

  box_frustum_cull_test DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .x_min_i         (x_min_i),
    .y_min_i         (y_min_i),
    .z_min_i         (z_min_i),
    .x_max_i         (x_max_i),
    .y_max_i         (y_max_i),
    .z_max_i         (z_max_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cullable_o      (cullable_o),
    .common_outcode_o(common_outcode_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic box_t make_box(int xl, int yl, int zl, int xh, int yh, int zh);
    box_t b;
    b.lo[0] = xl;
    b.lo[1] = yl;
    b.lo[2] = zl;
    b.hi[0] = xh;
    b.hi[1] = yh;
    b.hi[2] = zh;
    return b;
  endfunction

  function automatic box_t random_box();
    box_t b;
    int sel;
    int ctr;
    int ext;
    int idx;
    sel = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      case (sel)
        0, 1: begin
          b.lo[a] = $urandom;
          b.hi[a] = $urandom;
        end
        8: begin
          b.lo[a] = $urandom;
          b.hi[a] = b.lo[a] + $urandom_range(0, 4 * Q1);
        end
        9: begin
          idx = $urandom_range(0, 5);
          b.lo[a] = (idx == 5) ? $urandom : EdgeVals[idx];
          idx = $urandom_range(0, 5);
          b.hi[a] = (idx == 5) ? $urandom : EdgeVals[idx];
        end
        default: begin
          ctr = int'($urandom_range(0, 8 * Q1)) - 4 * Q1;
          ext = $urandom_range(0, 2 * Q1);
          b.lo[a] = (sel == 7) ? ctr + ext : ctr - ext;
          b.hi[a] = (sel == 7) ? ctr - ext : ctr + ext;
        end
      endcase
    end
    return b;
  endfunction

  function automatic mat_t make_matrix(mat_kind_e kind);
    mat_t m;
    m = '0;
    case (kind)
      MX_IDENTITY: begin
        for (int i = 0; i < 4; i++) m[i][i] = OneM;
      end
      MX_PERSPECTIVE: begin
        m[0][0] = 3 * OneM / 2;
        m[0][2] = OneM / 4;
        m[1][1] = 2 * OneM;
        m[2][2] = -5 * OneM / 4;
        m[2][3] = -OneM / 2;
        m[3][2] = -OneM;
      end
      MX_SMALL_RANDOM: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) m[r][c] = int'($urandom_range(0, 4 * OneM)) - 2 * OneM;
      end
      MX_FULL_RANDOM: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) m[r][c] = $urandom;
      end
      MX_MOST_NEG: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) m[r][c] = 32'h8000_0000;
      end
      MX_MOST_POS: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) m[r][c] = 32'h7fff_ffff;
      end
      MX_ALTERNATING: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            m[r][c] = ((r + c) % 2 != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      end
      default: begin
        m = '0;
      end
    endcase
    return m;
  endfunction

  task automatic load_matrix(mat_t m);
    logic [RegW-1:0] word;
    for (int i = 0; i < NumRegs; i++) begin
      word = {m[i / 2][(i % 2) * 2 + 1], m[i / 2][(i % 2) * 2]};
      cfg_we_i <= 1'b1;
      cfg_idx_i <= reg_idx_e'(i);
      cfg_wdata_i <= word;
      @(posedge clk_i);
      sb.write_reg(reg_idx_e'(i), word);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_box(box_t b, int gap);
    in_valid_i <= 1'b1;
    x_min_i <= b.lo[0];
    y_min_i <= b.lo[1];
    z_min_i <= b.lo[2];
    x_max_i <= b.hi[0];
    y_max_i <= b.hi[1];
    z_max_i <= b.hi[2];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_box(b);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_outcodes.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, plus long hold-offs on request so the pipeline backs up.
  initial begin
    int hold_cycles;
    int rx_pause;
    hold_cycles = 0;
    rx_pause = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cycles = LongHold;
        n_long_holds++;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (rx_pause > 0) begin
        rx_pause--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        rx_pause = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(cullable_o, common_outcode_o);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_box_frustum_cull_test: FAIL");
    $finish;
  end

  initial begin
    mat_kind_e plan [NumPhases];
    box_t directed [$];
    sb = new();
    no_idle = 1'b0;
    long_hold_req = 1'b0;
    n_long_holds = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    x_min_i = '0;
    y_min_i = '0;
    z_min_i = '0;
    x_max_i = '0;
    y_max_i = '0;
    z_max_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ROW0_COLS01;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix from reset: plane tests, extremes and inverted boxes.
    directed.push_back(make_box(0, 0, 0, 0, 0, 0));
    directed.push_back(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    directed.push_back(make_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    directed.push_back(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    directed.push_back(make_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    directed.push_back(make_box(2 * Q1, -Q1 / 2, -Q1 / 2, 3 * Q1, Q1 / 2, Q1 / 2));
    directed.push_back(make_box(-3 * Q1, -Q1 / 2, -Q1 / 2, -2 * Q1, Q1 / 2, Q1 / 2));
    directed.push_back(make_box(-Q1 / 2, 2 * Q1, -Q1 / 2, Q1 / 2, 3 * Q1, Q1 / 2));
    directed.push_back(make_box(-Q1 / 2, -3 * Q1, -Q1 / 2, Q1 / 2, -2 * Q1, Q1 / 2));
    directed.push_back(make_box(-Q1 / 2, -Q1 / 2, 2 * Q1, Q1 / 2, Q1 / 2, 3 * Q1));
    directed.push_back(make_box(-Q1 / 2, -Q1 / 2, -3 * Q1, Q1 / 2, Q1 / 2, -2 * Q1));
    directed.push_back(make_box(Q1, -Q1 / 2, -Q1 / 2, 2 * Q1, Q1 / 2, Q1 / 2));
    directed.push_back(make_box(Q1 + 1, -Q1 / 2, -Q1 / 2, 2 * Q1, Q1 / 2, Q1 / 2));
    directed.push_back(make_box(-2 * Q1, -Q1 / 2, -Q1 / 2, -Q1, Q1 / 2, Q1 / 2));
    directed.push_back(make_box(-2 * Q1, -Q1 / 2, -Q1 / 2, -Q1 - 1, Q1 / 2, Q1 / 2));
    directed.push_back(make_box(-Q1 / 2, -Q1 / 2, Q1, Q1 / 2, Q1 / 2, 2 * Q1));
    directed.push_back(make_box(-Q1 / 2, -2 * Q1, -Q1 / 2, Q1 / 2, -Q1 - 1, Q1 / 2));
    directed.push_back(make_box(3 * Q1, -Q1 / 2, -Q1 / 2, 2 * Q1, Q1 / 2, Q1 / 2));
    directed.push_back(make_box(Q1 / 2, Q1 / 2, Q1 / 2, -Q1 / 2, -Q1 / 2, -Q1 / 2));
    directed.push_back(make_box(2 * Q1, 2 * Q1, -Q1 / 2, 3 * Q1, 3 * Q1, Q1 / 2));
    foreach (directed[i]) send_box(directed[i], pick_gap());
    in_valid_i <= 1'b0;

    plan = '{MX_IDENTITY, MX_PERSPECTIVE, MX_SMALL_RANDOM, MX_SMALL_RANDOM, MX_FULL_RANDOM,
             MX_MOST_NEG, MX_MOST_POS, MX_ZERO, MX_ALTERNATING, MX_SMALL_RANDOM};
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      repeat (2) @(posedge clk_i);
      load_matrix(make_matrix(plan[p]));
      no_idle = (p % 3 == 0);
      if (p == 3 || p == 9) long_hold_req = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) send_box(random_box(), pick_gap());
      in_valid_i <= 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d of %0d boxes under %0d matrix settings: %0d culled, %0d kept.",
             sb.n_checked, sb.n_noted, NumPhases + 1, sb.n_culled, sb.n_checked - sb.n_culled);
    $display("Outcode bits seen set: %06b; long result-side hold-offs: %0d; mismatches: %0d.",
             sb.bits_seen, n_long_holds, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_outcodes.size() == 0) begin
      $display("tb_box_frustum_cull_test: PASS");
    end else begin
      $display("tb_box_frustum_cull_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bfc_pkg.sv
rtl/bfc_mat_regs.sv
rtl/bfc_xform.sv
rtl/bfc_outcode.sv
rtl/box_frustum_cull_test.sv
rtl/bfc_checker.sv
verif/tb_box_frustum_cull_test.sv
